FILE: rtl/core/pfd_pkg.sv
// Shared types, constants and helper functions for the Playfair digraph cipher unit.
package pfd_pkg;

    // Square geometry and letter coding.
    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int ALPHABET    = 26;
    localparam int LETTER_W    = 5;
    localparam int CELL_W      = $clog2(CELLS);
    localparam int COORD_W     = $clog2(SQUARE_SIDE);
    localparam int QUEUE_DEPTH = 4;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

    // Input item kinds.
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    // Command codes passed from the front to the back.
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_PAIR = 1'b1;

    // Configuration register map.
    localparam int          PADDR_W          = 3;
    localparam int          PDATA_W          = 32;
    localparam logic [0:0]  REG_DECRYPT_MODE = 1'b0;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [COORD_W-1:0]  t_coord;
    typedef logic [CELL_W-1:0]   t_cell;

    typedef struct packed {
        logic    kind;
        t_letter letter;
        logic    last;
    } t_in_item;

    typedef struct packed {
        t_letter first_out;
        t_letter second_out;
        logic    pair_last;
    } t_out_item;

    // One unit of work for the back: a key letter (a, fin = fill after it)
    // or a text pair (a, b, fin = final pair of the message).
    typedef struct packed {
        logic    op;
        t_letter a;
        t_letter b;
        logic    fin;
    } t_cmd;

    // Queue occupancy flags seen by both sides.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Folds a raw letter code: codes above Z saturate to Z, J becomes I.
    function automatic t_letter fold_letter(input t_letter raw);
        t_letter v;
        begin
            v = (raw > LETTER_Z) ? LETTER_Z : raw;
            if (v == LETTER_J) begin
                v = LETTER_I;
            end
            return v;
        end
    endfunction

    // Moves a row or column one step, forward or back, around the square.
    function automatic t_coord shift_coord(input t_coord x, input logic back);
        begin
            if (back) begin
                return (x == '0) ? COORD_W'(SQUARE_SIDE - 1) : t_coord'(x - 1'b1);
            end
            return (x == COORD_W'(SQUARE_SIDE - 1)) ? '0 : t_coord'(x + 1'b1);
        end
    endfunction

    // Row-major cell index of a square position.
    function automatic t_cell cell_addr(input t_coord row, input t_coord col);
        begin
            return CELL_W'(int'(row) * SQUARE_SIDE + int'(col));
        end
    endfunction

endpackage

FILE: rtl/core/pfd_front.sv
// Front part: folds letters, forms text pairs and issues commands to the queue.
module pfd_front
    import pfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    input  t_q_status i_q_stat,
    output logic      o_push,
    output t_cmd      o_cmd,
    output logic      o_extra_v
);

    logic    r_pend_v;
    t_letter r_pend;
    logic    r_extra_v;
    t_cmd    r_extra;

    logic    n_pend_v;
    t_letter n_pend;
    logic    accept;
    t_letter v;
    logic    has1;
    logic    has_extra;
    t_cmd    cmd1;
    t_cmd    cmd_extra;

    // A held second pair blocks new transfers until it reaches the queue.
    assign o_in_stall = r_extra_v || i_q_stat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign v          = fold_letter(i_in_data.letter);

    // Classify the item and work out the commands it causes.
    always_comb begin
        has1      = 1'b0;
        has_extra = 1'b0;
        cmd1      = '{op: CMD_KEY, a: v, b: LETTER_Z, fin: i_in_data.last};
        cmd_extra = '{op: CMD_PAIR, a: v, b: LETTER_Z, fin: 1'b1};
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        if (i_in_data.kind == KIND_KEY) begin
            has1 = 1'b1;
        end else if (!r_pend_v) begin
            if (i_in_data.last) begin
                has1 = 1'b1;
                cmd1 = '{op: CMD_PAIR, a: v, b: LETTER_Z, fin: 1'b1};
            end else begin
                n_pend_v = 1'b1;
                n_pend   = v;
            end
        end else if (r_pend == v) begin
            // Doubled letter: the pending one goes out with the filler.
            has1 = 1'b1;
            cmd1 = '{op: CMD_PAIR, a: r_pend, b: LETTER_Z, fin: 1'b0};
            if (i_in_data.last) begin
                has_extra = 1'b1;
                n_pend_v  = 1'b0;
                n_pend    = '0;
            end
        end else begin
            has1     = 1'b1;
            cmd1     = '{op: CMD_PAIR, a: r_pend, b: v, fin: i_in_data.last};
            n_pend_v = 1'b0;
            n_pend   = '0;
        end
    end

    assign o_push    = r_extra_v ? !i_q_stat.full : (accept && has1);
    assign o_cmd     = r_extra_v ? r_extra : cmd1;
    assign o_extra_v = r_extra_v;

    // Pairing state and the held second pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v  <= 1'b0;
            r_pend    <= '0;
            r_extra_v <= 1'b0;
        end else begin
            if (accept) begin
                r_pend_v <= n_pend_v;
                r_pend   <= n_pend;
                if (has_extra) begin
                    r_extra_v <= 1'b1;
                end
            end else if (r_extra_v && !i_q_stat.full) begin
                r_extra_v <= 1'b0;
            end
        end
    end

    // Payload of the held pair needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept && has_extra) begin
            r_extra <= cmd_extra;
        end
    end

endmodule

FILE: rtl/core/pfd_queue.sv
// Command queue between the front and the back.
module pfd_queue
    import pfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : PW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : PW'(r_rd + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

endmodule

FILE: rtl/core/pfd_back.sv
// Back part: builds the square from key letters and ciphers text pairs.
module pfd_back
    import pfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_decrypt,
    input  t_cmd      i_head,
    input  t_q_status i_q_stat,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_KEY  = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_RDA  = 3'd3;
    localparam logic [2:0] S_RDB  = 3'd4;
    localparam logic [2:0] S_CALC = 3'd5;
    localparam logic [2:0] S_RD2  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // Square contents and the reverse map from letter to position.
    t_letter                 sq_mem  [CELLS];
    logic [2*COORD_W-1:0]    pos_mem [ALPHABET];
    t_letter                 sq_q;
    logic [2*COORD_W-1:0]    pos_q;

    logic [2:0]              r_state;
    t_cmd                    r_cmd;
    t_letter                 r_c;
    logic [CELL_W-1:0]       r_fill;
    t_coord                  r_frow;
    t_coord                  r_fcol;
    logic [ALPHABET-1:0]     r_used;
    t_coord                  r_pa_row;
    t_coord                  r_pa_col;
    t_cell                   r_o2;
    t_letter                 r_first;
    logic                    r_out_v;
    t_out_item               r_out;

    logic                    place_en;
    t_letter                 place_letter;
    t_cell                   sq_raddr;
    t_letter                 pos_raddr;
    t_coord                  pb_row;
    t_coord                  pb_col;
    t_cell                   o1;
    t_cell                   o2;
    logic                    out_free;

    assign out_free    = !r_out_v || !i_out_stall;
    assign o_pop       = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Letter placement for key letters and for the fill sweep.
    always_comb begin
        place_letter = r_cmd.a;
        place_en     = 1'b0;
        if (r_state == S_KEY) begin
            place_en = !r_used[r_cmd.a] && (r_fill < CELL_W'(CELLS));
        end else if (r_state == S_FILL) begin
            place_letter = r_c;
            place_en     = (r_c != LETTER_J) && !r_used[r_c] && (r_fill < CELL_W'(CELLS));
        end
    end

    // Read addresses for both memories.
    always_comb begin
        pos_raddr = (r_state == S_RDB) ? r_cmd.b : r_cmd.a;
        sq_raddr  = (r_state == S_CALC) ? o1 : r_o2;
    end

    // Position of the second letter; an absent letter sits at row 0, column 0.
    always_comb begin
        pb_row = r_used[r_cmd.b] ? pos_q[2*COORD_W-1:COORD_W] : '0;
        pb_col = r_used[r_cmd.b] ? pos_q[COORD_W-1:0] : '0;
    end

    // Row, column and rectangle rules.
    always_comb begin
        if (r_pa_row == pb_row) begin
            o1 = cell_addr(r_pa_row, shift_coord(r_pa_col, i_decrypt));
            o2 = cell_addr(pb_row, shift_coord(pb_col, i_decrypt));
        end else if (r_pa_col == pb_col) begin
            o1 = cell_addr(shift_coord(r_pa_row, i_decrypt), r_pa_col);
            o2 = cell_addr(shift_coord(pb_row, i_decrypt), pb_col);
        end else begin
            o1 = cell_addr(r_pa_row, pb_col);
            o2 = cell_addr(pb_row, r_pa_col);
        end
    end

    // Memory writes and registered reads.
    always_ff @(posedge i_clk) begin
        if (place_en) begin
            sq_mem[r_fill]        <= place_letter;
            pos_mem[place_letter] <= {r_frow, r_fcol};
        end
        sq_q  <= sq_mem[sq_raddr];
        pos_q <= pos_mem[pos_raddr];
    end

    // Sequencer and fill bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_frow  <= '0;
            r_fcol  <= '0;
            r_used  <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (place_en) begin
                r_used[place_letter] <= 1'b1;
                r_fill               <= CELL_W'(r_fill + 1'b1);
                if (r_fcol == COORD_W'(SQUARE_SIDE - 1)) begin
                    r_fcol <= '0;
                    r_frow <= t_coord'(r_frow + 1'b1);
                end else begin
                    r_fcol <= t_coord'(r_fcol + 1'b1);
                end
            end
            // The output register fills in the output state and empties on its transfer.
            if ((r_state == S_OUT) && out_free) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_state <= (i_head.op == CMD_KEY) ? S_KEY : S_RDA;
                    end
                end
                S_KEY: begin
                    r_state <= r_cmd.fin ? S_FILL : S_IDLE;
                end
                S_FILL: begin
                    if (r_c == LETTER_W'(ALPHABET - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Working registers of the current command.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (r_state == S_KEY) begin
            r_c <= '0;
        end else if (r_state == S_FILL) begin
            r_c <= t_letter'(r_c + 1'b1);
        end
        if (r_state == S_RDB) begin
            r_pa_row <= r_used[r_cmd.a] ? pos_q[2*COORD_W-1:COORD_W] : '0;
            r_pa_col <= r_used[r_cmd.a] ? pos_q[COORD_W-1:0] : '0;
        end
        if (r_state == S_CALC) begin
            r_o2 <= o2;
        end
        if (r_state == S_RD2) begin
            r_first <= sq_q;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out <= '{first_out: r_first, second_out: sq_q, pair_last: r_cmd.fin};
        end
    end

endmodule

FILE: rtl/core/playfair_digraph_cipher_unit.sv
// Top level of the Playfair digraph cipher unit: register port, front, queue and back.
//
// Key letters and text letters arrive as transfers on the input channel; the front takes
// one per cycle while the four-entry command queue has room and no second pair is held,
// which a doubled text letter marked last causes. The back sequencer takes a new command
// only from its idle state: a key letter passes through S_KEY, the last key letter adds
// a sweep over the alphabet in S_FILL that fills the rest of the square, and each text
// pair passes through S_RDA, S_RDB, S_CALC, S_RD2 and S_OUT, with two registered reads
// each of the position map and the square memory, waiting in S_OUT while the output is
// stalled. Text must only follow a complete key; the square holds one key until reset.
module playfair_digraph_cipher_unit
    import pfd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic      r_decrypt;
    logic      q_push;
    t_cmd      q_cmd;
    logic      q_pop;
    t_cmd      q_head;
    t_q_status q_stat;
    logic      extra_v;
    logic      reg_hit;

    // Register port: one register, written in the access phase.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_DECRYPT_MODE) && (paddr[1:0] == 2'b00);
    assign prdata  = reg_hit ? {{(PDATA_W-1){1'b0}}, r_decrypt} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_decrypt <= pwdata[0];
        end
    end

    pfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_stat   (q_stat),
        .o_push     (q_push),
        .o_cmd      (q_cmd),
        .o_extra_v  (extra_v)
    );

    pfd_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    pfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_decrypt   (r_decrypt),
        .i_head      (q_head),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // The front never pushes into a full queue, so no command is dropped.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full))
        else $error("command pushed into a full queue");

    // The back only takes a command when one is there.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty))
        else $error("command taken from an empty queue");

    // A held second pair keeps the input channel stalled.
    a_extra_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        extra_v |-> o_in_stall)
        else $error("input transfer possible while a second pair is held");

    // A second pair is only held after a transfer that caused it.
    a_extra_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(extra_v) |-> $past(i_in_valid && !o_in_stall))
        else $error("second pair held without an input transfer");

endmodule
